// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, muted during reset.
`define NTD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, muted during reset.
`define NTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ntd_pkg.sv =====
// Package: sentence record type, field positions, tags and decode helpers.
`timescale 1ns / 1ps

package ntd_pkg;

   localparam logic [7:0] TIME_POS       = 8'd7;
   localparam logic [7:0] SATS_POS       = 8'd44;
   localparam logic [7:0] DATE_SHORT_POS = 8'd25;
   localparam logic [7:0] DATE_LONG_POS  = 8'd53;
   localparam logic [7:0] SHORT_COMMA_POS = 8'd26;
   localparam logic [7:0] LONG_STAR_POS  = 8'd57;
   localparam logic [7:0] RMC_SHORT_LEN  = 8'd38;
   localparam logic [7:0] RMC_LONG_MIN   = 8'd59;
   localparam logic [7:0] GGA_MIN_LEN    = 8'd8;
   localparam logic [7:0] TAG_LEN        = 8'd6;
   localparam logic [7:0] POS_MAX        = 8'hFF;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [7:0] GGA_TAG [6] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
   localparam logic [7:0] RMC_TAG [6] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_GGA   = 2'd1;
   localparam logic [1:0] KIND_RMC   = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_TIME_SET   = 3'd1,
      OP_TIME_CLEAR = 3'd2,
      OP_DATE_SHORT = 3'd3,
      OP_DATE_LONG  = 3'd4
   } op_type;

   // One finished sentence: what to do to the stores, with decoded values.
   typedef struct packed {
      op_type     op;
      logic [1:0] kind;
      logic [6:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
      logic [6:0] sats;
      logic [6:0] day;
      logic [6:0] month;
      logic [6:0] year;
   } rec_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[CH_ZERO:CH_NINE]});
   endfunction

   function automatic logic all_digits(input logic [5:0][7:0] s);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 6; i++) begin
         ok = ok & is_digit(s[i]);
      end
      return ok;
   endfunction

   // Two-digit decode that stops at the first non-digit.
   function automatic logic [6:0] decode2(input logic [7:0] hi, input logic [7:0] lo);
      logic [6:0] dh;
      logic [6:0] dl;
      logic [6:0] res;
      dh = 7'(hi - CH_ZERO);
      dl = 7'(lo - CH_ZERO);
      if (!is_digit(hi)) begin
         res = 7'd0;
      end else if (!is_digit(lo)) begin
         res = dh;
      end else begin
         res = 7'((dh << 3) + (dh << 1) + dl);
      end
      return res;
   endfunction

endpackage

// ===== rtl/nmea_time_date_extractor_core.sv =====
// Top level: NMEA time and date extractor, front end, record queue and back end.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   req     | in        | req_valid/req_stall | char_in[7:0], last
//   rsp     | out       | rsp_valid/rsp_stall | hours..year, sat_count, fixes, kind
//
// One character transaction per cycle while req_stall is low. A result passes
// from the transaction that carries the last flag into the record queue and then
// into the output register. Throughput is set by the front end's single
// compare-and-capture step per character.
// Reset (synchronous, active high) clears the position counter, tag matches,
// markers, stores and fix flags; stores read as zero until a sentence fills them.
// A stalled result holds the output register; the two-entry queue then fills,
// and req_stall rises only once both entries are in use.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmea_time_date_extractor_core import ntd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_hours,
   output logic [6:0] rsp_minutes,
   output logic [6:0] rsp_seconds,
   output logic [6:0] rsp_day,
   output logic [6:0] rsp_month,
   output logic [6:0] rsp_year,
   output logic [6:0] rsp_sat_count,
   output logic       rsp_time_fix,
   output logic       rsp_date_fix,
   output logic [1:0] rsp_sentence_kind
);

   logic    q_full;
   logic    push_valid;
   rec_type push_rec;
   logic    pop_valid;
   logic    pop_ready;
   rec_type pop_rec;

   // Front end: classify the sentence, capture field windows, build a record
   // on the last character.
   ntd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_char_in (req_char_in),
      .req_last    (req_last),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_rec    (push_rec)
   );

   // Decouple the two halves so a stalled result does not stop character intake.
   ntd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .q_full     (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   // Back end: update time, date and satellite stores, register the result.
   ntd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_rec           (pop_rec),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hours         (rsp_hours),
      .rsp_minutes       (rsp_minutes),
      .rsp_seconds       (rsp_seconds),
      .rsp_day           (rsp_day),
      .rsp_month         (rsp_month),
      .rsp_year          (rsp_year),
      .rsp_sat_count     (rsp_sat_count),
      .rsp_time_fix      (rsp_time_fix),
      .rsp_date_fix      (rsp_date_fix),
      .rsp_sentence_kind (rsp_sentence_kind)
   );

   // A finished sentence must land in the queue on the next cycle.
   `NTD_ASSERT_NEXT(a_last_queued, req_valid && !req_stall && req_last, pop_valid, "sentence end lost before queue")
   // Without a time fix the time and satellite fields must read zero.
   `NTD_ASSERT_IMPL(a_no_fix_zero, rsp_valid && !rsp_time_fix, rsp_hours == 7'd0 && rsp_minutes == 7'd0 && rsp_seconds == 7'd0 && rsp_sat_count == 7'd0, "time fields set without time fix")
   // Kind code three is never produced.
   `NTD_ASSERT_IMPL(a_kind_legal, rsp_valid, rsp_sentence_kind != 2'd3, "illegal sentence kind")

endmodule

// ===== rtl/ntd_front.sv =====
// Front end: counts characters, captures field windows, builds one record per sentence.
`timescale 1ns / 1ps

module ntd_front import ntd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_char_in,
   input  logic       req_last,
   output logic       req_stall,
   input  logic       q_full,
   output logic       push_valid,
   output rec_type    push_rec
);

   logic [7:0]      pos_ff, pos_in;
   logic [1:0]      prefix_ff, prefix_in;
   logic [2:0]      mark_ff, mark_in;
   logic [5:0][7:0] ptime_ff, ptime_in;
   logic [1:0][7:0] psats_ff, psats_in;
   logic [5:0][7:0] pshort_ff, pshort_in;
   logic [5:0][7:0] plong_ff, plong_in;
   logic [7:0]      len;
   logic            accept;
   logic [5:0][7:0] tmask;
   logic [1:0][7:0] smask;
   logic [5:0][7:0] dsel;
   logic [1:0]      kind;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign len       = (pos_ff == POS_MAX) ? POS_MAX : 8'(pos_ff + 8'd1);

   always_comb begin
      prefix_in = prefix_ff;
      mark_in   = mark_ff;
      ptime_in  = ptime_ff;
      psats_in  = psats_ff;
      pshort_in = pshort_ff;
      plong_in  = plong_ff;
      if (pos_ff < TAG_LEN) begin
         if (req_char_in != GGA_TAG[pos_ff[2:0]]) prefix_in[0] = 1'b0;
         if (req_char_in != RMC_TAG[pos_ff[2:0]]) prefix_in[1] = 1'b0;
      end
      if ((pos_ff == TIME_POS) && (req_char_in == CH_COMMA)) mark_in[0] = 1'b1;
      if ((pos_ff == SHORT_COMMA_POS) && (req_char_in == CH_COMMA)) mark_in[1] = 1'b1;
      if ((pos_ff == LONG_STAR_POS) && (req_char_in == CH_STAR)) mark_in[2] = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (pos_ff == 8'(TIME_POS + i)) ptime_in[i] = req_char_in;
         if (pos_ff == 8'(DATE_SHORT_POS + i)) pshort_in[i] = req_char_in;
         if (pos_ff == 8'(DATE_LONG_POS + i)) plong_in[i] = req_char_in;
      end
      for (int i = 0; i < 2; i++) begin
         if (pos_ff == 8'(SATS_POS + i)) psats_in[i] = req_char_in;
      end
   end

   // Positions the sentence never reached read as NUL.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         tmask[i] = (len > 8'(TIME_POS + i)) ? ptime_in[i] : CH_NUL;
      end
      for (int i = 0; i < 2; i++) begin
         smask[i] = (len > 8'(SATS_POS + i)) ? psats_in[i] : CH_NUL;
      end
   end

   always_comb begin
      kind = KIND_OTHER;
      if (len >= TAG_LEN) begin
         if (prefix_in[0]) kind = KIND_GGA;
         else if (prefix_in[1]) kind = KIND_RMC;
      end
   end

   always_comb begin
      dsel = (len == RMC_SHORT_LEN) ? pshort_in : plong_in;
      push_rec         = '0;
      push_rec.op      = OP_NONE;
      push_rec.kind    = kind;
      push_rec.hours   = decode2(tmask[0], tmask[1]);
      push_rec.minutes = decode2(tmask[2], tmask[3]);
      push_rec.seconds = decode2(tmask[4], tmask[5]);
      push_rec.sats    = decode2(smask[0], smask[1]);
      push_rec.day     = decode2(dsel[0], dsel[1]);
      push_rec.month   = decode2(dsel[2], dsel[3]);
      push_rec.year    = decode2(dsel[4], dsel[5]);
      if ((kind == KIND_GGA) && (len >= GGA_MIN_LEN)) begin
         push_rec.op = mark_in[0] ? OP_TIME_CLEAR : OP_TIME_SET;
      end else if (kind == KIND_RMC) begin
         if ((len == RMC_SHORT_LEN) && !mark_in[1] && all_digits(pshort_in)) begin
            push_rec.op = OP_DATE_SHORT;
         end else if ((len >= RMC_LONG_MIN) && !mark_in[2] && all_digits(plong_in)) begin
            push_rec.op = OP_DATE_LONG;
         end
      end
   end

   assign push_valid = accept & req_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         prefix_ff <= 2'b11;
         mark_ff   <= '0;
      end else if (accept) begin
         if (req_last) begin
            pos_ff    <= '0;
            prefix_ff <= 2'b11;
            mark_ff   <= '0;
         end else begin
            pos_ff    <= len;
            prefix_ff <= prefix_in;
            mark_ff   <= mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ptime_ff  <= ptime_in;
         psats_ff  <= psats_in;
         pshort_ff <= pshort_in;
         plong_ff  <= plong_in;
      end
   end

endmodule

// ===== rtl/ntd_queue.sv =====
// Two-entry record queue between the front end and the back end.
`timescale 1ns / 1ps

module ntd_queue import ntd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rec_type push_rec,
   output logic    q_full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rec_type pop_rec
);

   rec_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full    = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_rec   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~q_full;
   assign do_pop    = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

// ===== rtl/ntd_back.sv =====
// Back end: applies a sentence record to the stores and registers the result.
`timescale 1ns / 1ps

module ntd_back import ntd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  rec_type    pop_rec,
   output logic       pop_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_hours,
   output logic [6:0] rsp_minutes,
   output logic [6:0] rsp_seconds,
   output logic [6:0] rsp_day,
   output logic [6:0] rsp_month,
   output logic [6:0] rsp_year,
   output logic [6:0] rsp_sat_count,
   output logic       rsp_time_fix,
   output logic       rsp_date_fix,
   output logic [1:0] rsp_sentence_kind
);

   // Stores hold decoded values; a NUL store decodes to zero.
   logic [6:0] hours_ff, hours_in, minutes_ff, minutes_in, seconds_ff, seconds_in;
   logic [6:0] day_ff, day_in, month_ff, month_in, year_ff, year_in;
   logic [6:0] sats_ff, sats_in;
   logic       tfix_ff, tfix_in, dfix_ff, dfix_in;
   logic       valid_ff;
   logic [6:0] o_hours_ff, o_minutes_ff, o_seconds_ff;
   logic [6:0] o_day_ff, o_month_ff, o_year_ff, o_sats_ff;
   logic       o_tfix_ff, o_dfix_ff;
   logic [1:0] o_kind_ff;
   logic       take;

   assign pop_ready = ~valid_ff | ~rsp_stall;
   assign take      = pop_valid & pop_ready;

   always_comb begin
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      sats_in    = sats_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      tfix_in    = tfix_ff;
      dfix_in    = dfix_ff;
      case (pop_rec.op)
         OP_TIME_SET: begin
            hours_in   = pop_rec.hours;
            minutes_in = pop_rec.minutes;
            seconds_in = pop_rec.seconds;
            sats_in    = pop_rec.sats;
            tfix_in    = 1'b1;
         end
         OP_TIME_CLEAR: begin
            hours_in   = '0;
            minutes_in = '0;
            seconds_in = '0;
            sats_in    = '0;
            tfix_in    = 1'b0;
         end
         OP_DATE_SHORT, OP_DATE_LONG: begin
            day_in   = pop_rec.day;
            month_in = pop_rec.month;
            year_in  = pop_rec.year;
            dfix_in  = (pop_rec.op == OP_DATE_LONG);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
         sats_ff    <= '0;
         day_ff     <= '0;
         month_ff   <= '0;
         year_ff    <= '0;
         tfix_ff    <= 1'b0;
         dfix_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (take) begin
            hours_ff   <= hours_in;
            minutes_ff <= minutes_in;
            seconds_ff <= seconds_in;
            sats_ff    <= sats_in;
            day_ff     <= day_in;
            month_ff   <= month_in;
            year_ff    <= year_in;
            tfix_ff    <= tfix_in;
            dfix_ff    <= dfix_in;
            valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         o_hours_ff   <= hours_in;
         o_minutes_ff <= minutes_in;
         o_seconds_ff <= seconds_in;
         o_sats_ff    <= sats_in;
         o_day_ff     <= day_in;
         o_month_ff   <= month_in;
         o_year_ff    <= year_in;
         o_tfix_ff    <= tfix_in;
         o_dfix_ff    <= dfix_in;
         o_kind_ff    <= pop_rec.kind;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_hours         = o_hours_ff;
   assign rsp_minutes       = o_minutes_ff;
   assign rsp_seconds       = o_seconds_ff;
   assign rsp_day           = o_day_ff;
   assign rsp_month         = o_month_ff;
   assign rsp_year          = o_year_ff;
   assign rsp_sat_count     = o_sats_ff;
   assign rsp_time_fix      = o_tfix_ff;
   assign rsp_date_fix      = o_dfix_ff;
   assign rsp_sentence_kind = o_kind_ff;

endmodule

// ===== tb/nmea_time_date_extractor_core_test.sv =====
// Testbench for the NMEA time and date extractor: directed and random sentences, self-checking.
`timescale 1ns / 1ps

module nmea_time_date_extractor_core_test import ntd_pkg::*;;

   // One decoded report as the block should present it after a sentence ends.
   typedef struct {
      logic [6:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
      logic [6:0] day;
      logic [6:0] month;
      logic [6:0] year;
      logic [6:0] sats;
      logic       time_fix;
      logic       date_fix;
      logic [1:0] kind;
   } sentence_report_type;

   localparam logic [0:5][7:0] GGA_PREFIX = "$GPGGA";
   localparam logic [0:5][7:0] RMC_PREFIX = "$GPRMC";

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_hours;
   logic [6:0] rsp_minutes;
   logic [6:0] rsp_seconds;
   logic [6:0] rsp_day;
   logic [6:0] rsp_month;
   logic [6:0] rsp_year;
   logic [6:0] rsp_sat_count;
   logic       rsp_time_fix;
   logic       rsp_date_fix;
   logic [1:0] rsp_sentence_kind;

   nmea_time_date_extractor_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hours         (rsp_hours),
      .rsp_minutes       (rsp_minutes),
      .rsp_seconds       (rsp_seconds),
      .rsp_day           (rsp_day),
      .rsp_month         (rsp_month),
      .rsp_year          (rsp_year),
      .rsp_sat_count     (rsp_sat_count),
      .rsp_time_fix      (rsp_time_fix),
      .rsp_date_fix      (rsp_date_fix),
      .rsp_sentence_kind (rsp_sentence_kind)
   );

   // Parser shadow: per-sentence capture state.
   int              parse_pos;
   bit              gga_possible;
   bit              rmc_possible;
   logic [0:5][7:0] time_buf;
   logic [0:1][7:0] sats_buf;
   logic [0:5][7:0] date_short_buf;
   logic [0:5][7:0] date_long_buf;
   bit              comma_at_time;
   bit              comma_in_short;
   bit              star_in_long;

   // Parser shadow: state kept across sentences.
   logic [0:5][7:0] time_store_q;
   logic [0:1][7:0] sats_store_q;
   logic [0:5][7:0] date_store_q;
   bit              time_fix_q;
   bit              date_fix_q;

   sentence_report_type sentence_reports_q[$];
   logic [7:0]          sentence_buf[$];
   int                  mismatch_count = 0;
   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Decode up to two digits; stop at the first non-digit.
   function automatic logic [6:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
      int v;
      v = 0;
      if (is_numeral(hi)) begin
         v = hi - "0";
         if (is_numeral(lo)) begin
            v = v * 10 + (lo - "0");
         end
      end
      return 7'(v);
   endfunction

   function automatic bit all_numerals(input logic [0:5][7:0] w);
      bit ok;
      ok = 1'b1;
      for (int i = 0; i < 6; i++) begin
         ok = ok & is_numeral(w[i]);
      end
      return ok;
   endfunction

   task automatic restart_sentence();
      parse_pos      = 0;
      gga_possible   = 1'b1;
      rmc_possible   = 1'b1;
      time_buf       = '0;
      sats_buf       = '0;
      date_short_buf = '0;
      date_long_buf  = '0;
      comma_at_time  = 1'b0;
      comma_in_short = 1'b0;
      star_in_long   = 1'b0;
   endtask

   // Advance the shadow parser by one accepted character; queue a report on the last one.
   task automatic advance_parser(input logic [7:0] c, input logic is_last);
      int                  p;
      int                  len;
      sentence_report_type r;
      p = parse_pos;
      if (p < TAG_LEN) begin
         if (c != GGA_PREFIX[p]) gga_possible = 1'b0;
         if (c != RMC_PREFIX[p]) rmc_possible = 1'b0;
      end
      // Capture every window the character falls into.
      if (p >= TIME_POS && p < TIME_POS + 6) time_buf[p - TIME_POS] = c;
      if (p >= SATS_POS && p < SATS_POS + 2) sats_buf[p - SATS_POS] = c;
      if (p >= DATE_SHORT_POS && p < DATE_SHORT_POS + 6) date_short_buf[p - DATE_SHORT_POS] = c;
      if (p >= DATE_LONG_POS && p < DATE_LONG_POS + 6) date_long_buf[p - DATE_LONG_POS] = c;
      if (p == TIME_POS && c == CH_COMMA) comma_at_time = 1'b1;
      if (p == SHORT_COMMA_POS && c == CH_COMMA) comma_in_short = 1'b1;
      if (p == LONG_STAR_POS && c == CH_STAR) star_in_long = 1'b1;
      // Saturate the length at the top of the counter.
      len = (p < POS_MAX) ? p + 1 : POS_MAX;
      parse_pos = len;
      if (is_last) begin
         r.kind = KIND_OTHER;
         if (len >= TAG_LEN) begin
            if (gga_possible) r.kind = KIND_GGA;
            else if (rmc_possible) r.kind = KIND_RMC;
         end
         if (r.kind == KIND_GGA && len >= GGA_MIN_LEN) begin
            // An empty time field wipes time and satellites and drops the time fix.
            if (comma_at_time) begin
               time_store_q = '0;
               sats_store_q = '0;
               time_fix_q   = 1'b0;
            end else begin
               time_store_q = time_buf;
               sats_store_q = sats_buf;
               time_fix_q   = 1'b1;
            end
         end else if (r.kind == KIND_RMC) begin
            if (len == RMC_SHORT_LEN) begin
               if (!comma_in_short && all_numerals(date_short_buf)) begin
                  date_store_q = date_short_buf;
                  date_fix_q   = 1'b0;
               end
            end else if (len > RMC_SHORT_LEN) begin
               if (!star_in_long && all_numerals(date_long_buf)) begin
                  date_store_q = date_long_buf;
                  date_fix_q   = 1'b1;
               end
            end
         end
         r.hours    = pair_value(time_store_q[0], time_store_q[1]);
         r.minutes  = pair_value(time_store_q[2], time_store_q[3]);
         r.seconds  = pair_value(time_store_q[4], time_store_q[5]);
         r.day      = pair_value(date_store_q[0], date_store_q[1]);
         r.month    = pair_value(date_store_q[2], date_store_q[3]);
         r.year     = pair_value(date_store_q[4], date_store_q[5]);
         r.sats     = pair_value(sats_store_q[0], sats_store_q[1]);
         r.time_fix = time_fix_q;
         r.date_fix = date_fix_q;
         sentence_reports_q.push_back(r);
         restart_sentence();
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_report();
      sentence_report_type want;
      if (sentence_reports_q.size() == 0) begin
         report_mismatch("result with none outstanding", 1, 0);
         return;
      end
      want = sentence_reports_q.pop_front();
      if (rsp_hours !== want.hours) report_mismatch("hours", rsp_hours, want.hours);
      if (rsp_minutes !== want.minutes) report_mismatch("minutes", rsp_minutes, want.minutes);
      if (rsp_seconds !== want.seconds) report_mismatch("seconds", rsp_seconds, want.seconds);
      if (rsp_day !== want.day) report_mismatch("day", rsp_day, want.day);
      if (rsp_month !== want.month) report_mismatch("month", rsp_month, want.month);
      if (rsp_year !== want.year) report_mismatch("year", rsp_year, want.year);
      if (rsp_sat_count !== want.sats) report_mismatch("sat_count", rsp_sat_count, want.sats);
      if (rsp_time_fix !== want.time_fix) report_mismatch("time_fix", rsp_time_fix, want.time_fix);
      if (rsp_date_fix !== want.date_fix) report_mismatch("date_fix", rsp_date_fix, want.date_fix);
      if (rsp_sentence_kind !== want.kind) begin
         report_mismatch("sentence_kind", rsp_sentence_kind, want.kind);
      end
   endtask

   // Check each accepted result against the oldest outstanding report, then pick
   // the stall for the next cycle. The check reads the stall that was in force at this edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_report();
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Offer one character, idling first at random; hold it until the block takes it.
   task automatic send_char(input logic [7:0] c, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_last    <= is_last;
      do @(posedge clock); while (req_stall);
      advance_parser(c, is_last);
   endtask

   task automatic send_sentence();
      for (int i = 0; i < sentence_buf.size(); i++) begin
         send_char(sentence_buf[i], i == sentence_buf.size() - 1);
      end
   endtask

   // Hold the sender until every outstanding report has come back.
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      while (sentence_reports_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly digits, with the separators and letters a real sentence carries, and now and then any byte.
   function automatic logic [7:0] pick_field_char();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 8'(8'h30 + $urandom_range(9));
      if (r < 75) return CH_COMMA;
      if (r < 80) return ".";
      if (r < 95) return 8'(8'h41 + $urandom_range(25));
      return 8'($urandom_range(255));
   endfunction

   task automatic fill_sentence(input int len, input bit raw);
      sentence_buf.delete();
      for (int i = 0; i < len; i++) begin
         sentence_buf.push_back(raw ? 8'($urandom_range(255)) : pick_field_char());
      end
   endtask

   // Overwrite from a position on; drop whatever runs past the end.
   task automatic put_text(input int at, input string s);
      for (int i = 0; i < s.len(); i++) begin
         if (at + i < sentence_buf.size()) sentence_buf[at + i] = s[i];
      end
   endtask

   task automatic put_digits(input int at, input int n);
      for (int i = at; i < at + n && i < sentence_buf.size(); i++) begin
         sentence_buf[i] = ($urandom_range(99) < 93) ? 8'(8'h30 + $urandom_range(9))
                                                     : pick_field_char();
      end
   endtask

   task automatic build_gga(input int len);
      fill_sentence(len, 1'b0);
      put_text(0, "$GPGGA,");
      put_digits(TIME_POS, 6);
      put_digits(SATS_POS, 2);
   endtask

   task automatic build_rmc(input int len);
      fill_sentence(len, 1'b0);
      put_text(0, "$GPRMC,");
      put_digits(DATE_SHORT_POS, 6);
      put_digits(DATE_LONG_POS, 6);
   endtask

   // Short sentences, foreign tags and a tag broken in its last letter.
   task automatic test_sentence_kinds();
      // A lone '$' comes first so that no capture window is read before it was ever filled.
      fill_sentence(1, 1'b0);
      put_text(0, "$");
      send_sentence();
      fill_sentence(5, 1'b0);
      put_text(0, "$GPGG");
      send_sentence();
      fill_sentence(18, 1'b0);
      put_text(0, "$GPTXT,01,01,02,OK");
      send_sentence();
      build_gga(60);
      put_text(5, "B");
      send_sentence();
      wait_for_reports();
   endtask

   // Time and satellite capture, the empty time field and GGA sentences cut short.
   task automatic test_gga_time();
      build_gga(72);
      put_text(TIME_POS, "235959");
      put_text(SATS_POS, "12");
      send_sentence();
      build_gga(50);
      put_text(TIME_POS, "1A2B3C");
      put_text(SATS_POS, "7,");
      send_sentence();
      build_gga(20);
      put_text(TIME_POS, ",");
      send_sentence();
      build_gga(72);
      put_text(TIME_POS, "999999");
      put_text(SATS_POS, "99");
      send_sentence();
      // Too short to touch the stores, then just long enough.
      build_gga(7);
      send_sentence();
      build_gga(8);
      put_text(TIME_POS, "4");
      send_sentence();
      build_gga(45);
      put_text(TIME_POS, "000000");
      put_text(SATS_POS, "9");
      send_sentence();
      wait_for_reports();
   endtask

   // Short and long RMC dates, each kind of rejection, lengths around the limits.
   task automatic test_rmc_date();
      build_rmc(38);
      put_text(DATE_SHORT_POS, "311299");
      send_sentence();
      build_rmc(38);
      put_text(DATE_SHORT_POS, "0,0101");
      send_sentence();
      build_rmc(38);
      put_text(DATE_SHORT_POS, "12X456");
      send_sentence();
      build_rmc(37);
      put_text(DATE_SHORT_POS, "222222");
      send_sentence();
      build_rmc(59);
      put_text(DATE_LONG_POS, "010100");
      send_sentence();
      build_rmc(70);
      put_text(DATE_LONG_POS, "2512*5");
      send_sentence();
      build_rmc(50);
      send_sentence();
      build_rmc(64);
      put_text(DATE_LONG_POS, "999999");
      send_sentence();
      wait_for_reports();
   endtask

   // Sentences past the counter's top, and raw byte values including NUL and 0xFF.
   task automatic test_long_and_raw_bytes();
      build_rmc(300);
      put_text(DATE_LONG_POS, "150688");
      for (int i = 100; i < 300; i++) begin
         sentence_buf[i] = (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? CH_NUL : 8'($urandom_range(255)));
      end
      send_sentence();
      build_gga(260);
      for (int i = 60; i < 260; i++) begin
         sentence_buf[i] = 8'(8'h80 + $urandom_range(127));
      end
      send_sentence();
      fill_sentence(30, 1'b1);
      sentence_buf[3]  = CH_NUL;
      sentence_buf[10] = 8'hFF;
      send_sentence();
      wait_for_reports();
   endtask

   // Mostly well-formed GGA and RMC sentences with random content, the rest broken or noise.
   task automatic send_random_sentence();
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 35) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(6, 45) : $urandom_range(46, 85);
         build_gga(len);
         if ($urandom_range(9) == 0) put_text(TIME_POS, ",");
      end else if (pick < 55) begin
         build_rmc(RMC_SHORT_LEN);
         if ($urandom_range(9) == 0) put_text(SHORT_COMMA_POS, ",");
      end else if (pick < 75) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(39, 58) : $urandom_range(59, 90);
         build_rmc(len);
         if ($urandom_range(9) == 0) put_text(LONG_STAR_POS, "*");
      end else if (pick < 85) begin
         // Break one letter of a tag.
         len = $urandom_range(1, 60);
         if ($urandom_range(1)) build_gga(len);
         else build_rmc(len);
         len = $urandom_range(5);
         if (len < sentence_buf.size()) sentence_buf[len] = 8'($urandom_range(255));
      end else if (pick < 98) begin
         fill_sentence($urandom_range(1, 40), 1'b1);
      end else begin
         len = $urandom_range(256, 300);
         if ($urandom_range(1)) build_gga(len);
         else build_rmc(len);
      end
      send_sentence();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int chars);
      int sent;
      int sentences;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent      = 0;
      sentences = 0;
      while (sent < chars || sentences < 3) begin
         send_random_sentence();
         sent += sentence_buf.size();
         sentences++;
      end
      // Let the block run dry before the idling pattern changes.
      wait_for_reports();
   endtask

   initial begin
      restart_sentence();
      time_store_q = '0;
      sats_store_q = '0;
      date_store_q = '0;
      time_fix_q   = 1'b0;
      date_fix_q   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sentence_kinds();
      test_gga_time();
      test_rmc_date();
      test_long_and_raw_bytes();
      test_random_traffic(0, 0, 120);
      test_random_traffic(73, 0, 120);
      test_random_traffic(0, 73, 120);
      test_random_traffic(35, 35, 120);

      rsp_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
